// File: src/mcsd_pkg.sv
// mcsd_pkg: shared types and constants for the midi clock step divider
// no dependencies; used by every module of the block
`default_nettype none

package mcsd_pkg;

   localparam int unsigned DIV_W       = 7;
   localparam int unsigned WAIT_W      = 8;
   localparam int unsigned GRID_W      = 3;
   localparam int unsigned CSR_IDX_W   = 2;
   localparam int unsigned CSR_DATA_W  = 7;

   localparam logic [DIV_W-1:0]  DIV_MAX         = 7'd96;
   localparam logic [DIV_W-1:0]  DIV_MIN         = 7'd1;
   localparam logic [DIV_W-1:0]  DIV_RESET       = 7'd6;
   localparam logic [GRID_W-1:0] SIXTEENTH_LAST  = 3'd5;

   typedef enum logic [2:0] {
      OP_TICK     = 3'd0,
      OP_START    = 3'd1,
      OP_CONTINUE = 3'd2,
      OP_STOP     = 3'd3,
      OP_DIV_REQ  = 3'd4,
      OP_CNT_RST  = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_SIXTEENTH = 2'd1,
      KIND_TRIPLET   = 2'd2
   } grid_kind_type;

   typedef enum logic [1:0] {
      QM_BOUNDARY = 2'd0,
      QM_GRID     = 2'd1,
      QM_START    = 2'd2
   } quant_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_QUANTIZE_MODE = 2'd0,
      CSR_PHASE_TICKS   = 2'd1,
      CSR_RUN_ENABLE    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]       opcode;
      logic [DIV_W-1:0] new_division;
   } req_item_type;

   typedef struct packed {
      logic step_fire;
      logic sequence_reset;
      logic all_notes_off;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]       quantize_mode;
      logic [DIV_W-1:0] phase_ticks;
      logic             run_enable;
      logic             run_off_wr;   // pulse: run switch written to zero
   } cfg_type;

endpackage

`default_nettype wire

// File: src/mcsd_csr.sv
// mcsd_csr: configuration registers of the midi clock step divider
// depends on mcsd_pkg
`default_nettype none

module mcsd_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   input  wire logic [mcsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mcsd_pkg::CSR_DATA_W-1:0]   csr_data,
   output mcsd_pkg::cfg_type                      cfg
);

   logic [1:0]                 quantize_mode_ff, quantize_mode_in;
   logic [mcsd_pkg::DIV_W-1:0] phase_ticks_ff, phase_ticks_in;
   logic                       run_enable_ff, run_enable_in;
   logic                       run_off_wr;

   always_comb begin
      quantize_mode_in = quantize_mode_ff;
      phase_ticks_in   = phase_ticks_ff;
      run_enable_in    = run_enable_ff;
      run_off_wr       = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            mcsd_pkg::CSR_QUANTIZE_MODE: begin
               quantize_mode_in = csr_data[1:0];
            end
            mcsd_pkg::CSR_PHASE_TICKS: begin
               phase_ticks_in = csr_data[mcsd_pkg::DIV_W-1:0];
            end
            mcsd_pkg::CSR_RUN_ENABLE: begin
               run_enable_in = csr_data[0];
               run_off_wr    = ~csr_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quantize_mode_ff <= mcsd_pkg::QM_GRID;
         phase_ticks_ff   <= 7'd1;
         run_enable_ff    <= 1'b1;
      end else begin
         quantize_mode_ff <= quantize_mode_in;
         phase_ticks_ff   <= phase_ticks_in;
         run_enable_ff    <= run_enable_in;
      end
   end

   assign cfg.quantize_mode = quantize_mode_ff;
   assign cfg.phase_ticks   = phase_ticks_ff;
   assign cfg.run_enable    = run_enable_ff;
   assign cfg.run_off_wr    = run_off_wr;

endmodule

`default_nettype wire

// File: src/mcsd_core.sv
// mcsd_core: transport state and per-item update of the step divider
// depends on mcsd_pkg; result is registered by the top level
`default_nettype none

module mcsd_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_accept,
   input  mcsd_pkg::req_item_type req_item,
   input  mcsd_pkg::cfg_type      cfg,
   output mcsd_pkg::rsp_item_type result
);

   localparam int unsigned DW = mcsd_pkg::DIV_W;
   localparam int unsigned WW = mcsd_pkg::WAIT_W;
   localparam int unsigned GW = mcsd_pkg::GRID_W;

   logic [DW-1:0]           division_ff, division_in;
   logic [DW-1:0]           tick_ff, tick_in;
   logic [GW-1:0]           grid16_ff, grid16_in;
   logic [GW-1:0]           grid3_ff, grid3_in;
   logic [WW-1:0]           wait_ff, wait_in;
   logic                    armed_ff, armed_in;
   logic                    running_ff, running_in;
   logic [DW-1:0]           pend_bnd_ff, pend_bnd_in;
   logic [DW-1:0]           pend_start_ff, pend_start_in;
   logic [DW-1:0]           pend_grid_ff, pend_grid_in;
   mcsd_pkg::grid_kind_type pend_kind_ff, pend_kind_in;

   logic                    fire, seqrst, anoff;
   logic [GW-1:0]           g16_nx, g3_nx;
   logic                    grid_hit;
   logic [DW-1:0]           tick_nx, req_sat;
   logic [DW-1:0]           start_div;

   // phase offset, only honored when it is below the division
   function automatic logic [WW-1:0] eff_phase(input logic [DW-1:0] ph,
                                               input logic [DW-1:0] div);
      return (ph < div) ? {1'b0, ph} : '0;
   endfunction

   always_comb begin
      division_in   = division_ff;
      tick_in       = tick_ff;
      grid16_in     = grid16_ff;
      grid3_in      = grid3_ff;
      wait_in       = wait_ff;
      armed_in      = armed_ff;
      running_in    = running_ff;
      pend_bnd_in   = pend_bnd_ff;
      pend_start_in = pend_start_ff;
      pend_grid_in  = pend_grid_ff;
      pend_kind_in  = pend_kind_ff;
      fire          = 1'b0;
      seqrst        = 1'b0;
      anoff         = 1'b0;

      g16_nx   = (grid16_ff == mcsd_pkg::SIXTEENTH_LAST) ? '0 : grid16_ff + 1'b1;
      g3_nx    = grid3_ff + 1'b1;
      grid_hit = (pend_grid_ff != '0) &&
                 (((pend_kind_ff == mcsd_pkg::KIND_SIXTEENTH) && (g16_nx == '0)) ||
                  ((pend_kind_ff == mcsd_pkg::KIND_TRIPLET) && (g3_nx == '0)));
      tick_nx  = '0;
      start_div = (pend_start_ff != '0) ? pend_start_ff : division_ff;

      if (req_item.new_division < mcsd_pkg::DIV_MIN) begin
         req_sat = mcsd_pkg::DIV_MIN;
      end else if (req_item.new_division > mcsd_pkg::DIV_MAX) begin
         req_sat = mcsd_pkg::DIV_MAX;
      end else begin
         req_sat = req_item.new_division;
      end

      if (item_accept) begin
         case (req_item.opcode)
            mcsd_pkg::OP_TICK: begin
               if (running_ff) begin
                  grid16_in = g16_nx;
                  grid3_in  = g3_nx;
                  // grid-quantized change lands first and restarts the step
                  if (grid_hit) begin
                     division_in   = pend_grid_ff;
                     tick_in       = '0;
                     wait_in       = eff_phase(cfg.phase_ticks, pend_grid_ff);
                     armed_in      = 1'b1;
                     pend_bnd_in   = '0;
                     pend_start_in = '0;
                     pend_grid_in  = '0;
                     pend_kind_in  = mcsd_pkg::KIND_NONE;
                  end
                  tick_nx = tick_in + 1'b1;
                  tick_in = tick_nx;
                  if (tick_nx >= division_in) begin
                     tick_in = '0;
                     if ((pend_bnd_in != '0) && (pend_bnd_in != division_in)) begin
                        division_in = pend_bnd_in;
                        pend_bnd_in = '0;
                     end
                     wait_in  = eff_phase(cfg.phase_ticks, division_in);
                     armed_in = 1'b1;
                  end
                  if (armed_in) begin
                     if (wait_in != '0) begin
                        wait_in = wait_in - 1'b1;
                     end else begin
                        fire     = 1'b1;
                        armed_in = 1'b0;
                     end
                  end
               end
            end
            mcsd_pkg::OP_START: begin
               running_in  = 1'b1;
               tick_in     = '0;
               grid16_in   = '0;
               grid3_in    = '0;
               division_in = start_div;
               if (pend_start_ff != '0) begin
                  pend_start_in = '0;
               end
               // sum stays below 255, so no wrap needed
               wait_in  = {1'b0, start_div} + eff_phase(cfg.phase_ticks, start_div);
               armed_in = 1'b1;
               fire     = 1'b1;
               seqrst   = 1'b1;
            end
            mcsd_pkg::OP_CONTINUE: begin
               running_in = 1'b1;
            end
            mcsd_pkg::OP_STOP: begin
               running_in = 1'b0;
               armed_in   = 1'b0;
               anoff      = 1'b1;
            end
            mcsd_pkg::OP_DIV_REQ: begin
               pend_bnd_in   = '0;
               pend_start_in = '0;
               pend_grid_in  = '0;
               pend_kind_in  = mcsd_pkg::KIND_NONE;
               case (cfg.quantize_mode)
                  mcsd_pkg::QM_GRID: begin
                     pend_grid_in = req_sat;
                     pend_kind_in = (req_sat inside {7'd16, 7'd8, 7'd4, 7'd2}) ?
                                    mcsd_pkg::KIND_TRIPLET : mcsd_pkg::KIND_SIXTEENTH;
                  end
                  mcsd_pkg::QM_START: begin
                     pend_start_in = req_sat;
                  end
                  default: begin
                     pend_bnd_in = req_sat;
                  end
               endcase
            end
            mcsd_pkg::OP_CNT_RST: begin
               tick_in       = '0;
               wait_in       = '0;
               armed_in      = 1'b0;
               grid16_in     = '0;
               grid3_in      = '0;
               pend_bnd_in   = '0;
               pend_start_in = '0;
               pend_grid_in  = '0;
               pend_kind_in  = mcsd_pkg::KIND_NONE;
            end
            default: begin
            end
         endcase
         if (!cfg.run_enable) begin
            armed_in = 1'b0;
            fire     = 1'b0;
            seqrst   = 1'b0;
         end
      end else if (cfg.run_off_wr) begin
         armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         division_ff   <= mcsd_pkg::DIV_RESET;
         tick_ff       <= '0;
         grid16_ff     <= '0;
         grid3_ff      <= '0;
         wait_ff       <= '0;
         armed_ff      <= 1'b0;
         running_ff    <= 1'b0;
         pend_bnd_ff   <= '0;
         pend_start_ff <= '0;
         pend_grid_ff  <= '0;
         pend_kind_ff  <= mcsd_pkg::KIND_NONE;
      end else begin
         division_ff   <= division_in;
         tick_ff       <= tick_in;
         grid16_ff     <= grid16_in;
         grid3_ff      <= grid3_in;
         wait_ff       <= wait_in;
         armed_ff      <= armed_in;
         running_ff    <= running_in;
         pend_bnd_ff   <= pend_bnd_in;
         pend_start_ff <= pend_start_in;
         pend_grid_ff  <= pend_grid_in;
         pend_kind_ff  <= pend_kind_in;
      end
   end

   assign result.step_fire      = fire;
   assign result.sequence_reset = seqrst;
   assign result.all_notes_off  = anoff;

endmodule

`default_nettype wire

// File: src/midi_clock_step_divider_unit.sv
// midi_clock_step_divider_unit: top level of the midi clock step divider
// depends on mcsd_pkg, mcsd_csr and mcsd_core
`default_nettype none

// channel  | ports                             | direction | payload
// ---------+-----------------------------------+-----------+---------------------------
// req      | req_valid, req_stall, req_item    | in        | opcode, new_division
// rsp      | rsp_valid, rsp_stall, rsp_item    | out       | step_fire, sequence_reset,
//          |                                   |           | all_notes_off
// csr      | csr_valid, csr_ready, csr_index,  | in        | register index and data
//          | csr_data                          |           |
//
// one item per clock while req_stall is low: the transport state updates at the
// accept edge and the result is loaded into the output register at that same edge
// reset is synchronous active high; registers except the output payload come back to their reset values
// req_stall rises only when the output register is full and rsp_stall is high
// csr writes are always taken (csr_ready is tied high)

module midi_clock_step_divider_unit (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // item input
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  mcsd_pkg::req_item_type                 req_item,
   // result output
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output mcsd_pkg::rsp_item_type                 rsp_item,
   // configuration write
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [mcsd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [mcsd_pkg::CSR_DATA_W-1:0]   csr_data
);

   mcsd_pkg::cfg_type      cfg;
   mcsd_pkg::rsp_item_type result;
   logic                   item_accept;

   logic                   rsp_valid_ff, rsp_valid_in;
   mcsd_pkg::rsp_item_type rsp_item_ff, rsp_item_in;

   // new item may enter whenever the output slot is empty or drains this cycle
   assign req_stall   = rsp_valid_ff & rsp_stall;
   assign item_accept = req_valid & ~req_stall;
   assign csr_ready   = 1'b1;

   mcsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   mcsd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .req_item    (req_item),
      .cfg         (cfg),
      .result      (result)
   );

   // output register: load on accept, hold while stalled, empty when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      if (item_accept) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = result;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire
